// ===== src/iet_pkg.sv =====
// Shared types and constants of the input event translator.
// Used by every module of the block but iet_ram; depends on nothing.
`default_nettype none

package iet_pkg;

  localparam int SLOT_W_MAX = 6;
  localparam int CMD_DEPTH = 4;
  localparam int QUOT_W = 16;

  localparam logic [4:0] EVT_SYN = 5'd0;
  localparam logic [4:0] EVT_KEY = 5'd1;
  localparam logic [4:0] EVT_REL = 5'd2;
  localparam logic [4:0] EVT_ABS = 5'd3;
  localparam logic [4:0] EVT_MSC = 5'd4;

  localparam logic [9:0] KEY_TOUCH_BTN = 10'h14A;
  localparam logic [9:0] KEY_LEFT_BTN = 10'h110;

  localparam logic [9:0] RCODE_X = 10'h000;
  localparam logic [9:0] RCODE_Y = 10'h001;
  localparam logic [9:0] RCODE_HWHEEL = 10'h006;
  localparam logic [9:0] RCODE_WHEEL = 10'h008;

  localparam logic [9:0] ACODE_X = 10'h000;
  localparam logic [9:0] ACODE_Y = 10'h001;
  localparam logic [9:0] ACODE_WHEEL = 10'h008;
  localparam logic [9:0] ACODE_SLOT = 10'h02F;
  localparam logic [9:0] ACODE_MT_X = 10'h035;
  localparam logic [9:0] ACODE_MT_Y = 10'h036;
  localparam logic [9:0] ACODE_TRKID = 10'h039;

  localparam logic [2:0] KIND_PRESS = 3'd0;
  localparam logic [2:0] KIND_RELEASE = 3'd1;
  localparam logic [2:0] KIND_MOTION = 3'd2;
  localparam logic [2:0] KIND_WHEEL = 3'd3;
  localparam logic [2:0] KIND_TOUCH = 3'd4;

  localparam logic [2:0] CFG_MODE = 3'd0;
  localparam logic [2:0] CFG_SCREEN_W = 3'd1;
  localparam logic [2:0] CFG_SCREEN_H = 3'd2;
  localparam logic [2:0] CFG_X_MIN = 3'd3;
  localparam logic [2:0] CFG_X_MAX = 3'd4;
  localparam logic [2:0] CFG_Y_MIN = 3'd5;
  localparam logic [2:0] CFG_Y_MAX = 3'd6;

  typedef enum logic [1:0] {
    OP_EMIT,
    OP_AXIS,
    OP_TEND
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [2:0]             kind;
    logic [9:0]             code;
    logic                   is_y;
    logic [SLOT_W_MAX-1:0]  slot;
    logic signed [31:0]     value;
    logic signed [31:0]     rel_x;
    logic signed [31:0]     rel_y;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic [15:0]        screen_w;
    logic [15:0]        screen_h;
    logic signed [31:0] x_min;
    logic signed [31:0] x_max;
    logic signed [31:0] y_min;
    logic signed [31:0] y_max;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/iet_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
`default_nettype none

module iet_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/iet_front.sv =====
// Front end: accepts input events, filters and classifies them into commands.
// Holds the current touch slot. Depends on iet_pkg.
`default_nettype none

module iet_front #(
  parameter int TOUCH_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire iet_pkg::cfg_t      cfg,
  input  wire logic               push,
  input  wire logic [4:0]         event_type,
  input  wire logic [9:0]         event_code,
  input  wire logic signed [31:0] event_value,
  input  wire logic               full,
  output logic                    cmd_push,
  output iet_pkg::cmd_t           cmd
);

  import iet_pkg::*;

  localparam int SLOT_W = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

  logic [SLOT_W-1:0] cur_slot;
  logic              accept;
  logic              keep;
  logic              slot_hit;
  logic              mt_on;
  logic              mt_both;
  logic              in_range;

  assign accept = push && !full;
  assign mt_on = cfg.mode[0];
  assign mt_both = cfg.mode[0] && cfg.mode[1];
  assign in_range = !event_value[31] && (event_value[30:0] < 31'(TOUCH_SLOTS));
  assign slot_hit = !cfg.mode[2] && event_type == EVT_ABS && event_code == ACODE_SLOT &&
                    mt_on && in_range;
  assign cmd_push = accept && keep;

  always_comb begin
    keep = 1'b0;
    cmd = '0;
    cmd.op = OP_EMIT;
    cmd.slot = SLOT_W_MAX'(cur_slot);
    cmd.value = event_value;
    if (cfg.mode[2] || event_type inside {EVT_SYN, EVT_MSC}) begin
      keep = 1'b0;
    end else if (event_type == EVT_KEY) begin
      cmd.code = (event_code == KEY_TOUCH_BTN) ? KEY_LEFT_BTN : event_code;
      if (!mt_both && event_value == 32'sd0) begin
        keep = 1'b1;
        cmd.kind = KIND_RELEASE;
      end else if (!mt_both && event_value == 32'sd1) begin
        keep = 1'b1;
        cmd.kind = KIND_PRESS;
      end
    end else if (event_type == EVT_REL) begin
      case (event_code)
        RCODE_X: begin
          keep = 1'b1;
          cmd.kind = KIND_MOTION;
          cmd.rel_x = event_value;
        end
        RCODE_Y: begin
          keep = 1'b1;
          cmd.kind = KIND_MOTION;
          cmd.rel_y = event_value;
        end
        RCODE_HWHEEL: begin
          keep = 1'b1;
          cmd.kind = KIND_WHEEL;
          cmd.rel_x = event_value;
        end
        RCODE_WHEEL: begin
          keep = 1'b1;
          cmd.kind = KIND_WHEEL;
          cmd.rel_y = event_value;
        end
        default: keep = 1'b0;
      endcase
    end else if (event_type == EVT_ABS) begin
      case (event_code)
        ACODE_WHEEL: begin
          keep = 1'b1;
          cmd.kind = KIND_WHEEL;
          cmd.rel_y = event_value;
        end
        ACODE_X, ACODE_Y: begin
          keep = !mt_both;
          cmd.op = OP_AXIS;
          cmd.kind = KIND_MOTION;
          cmd.is_y = (event_code == ACODE_Y);
        end
        ACODE_MT_X, ACODE_MT_Y: begin
          keep = mt_on;
          cmd.op = OP_AXIS;
          cmd.kind = KIND_TOUCH;
          cmd.is_y = (event_code == ACODE_MT_Y);
        end
        ACODE_TRKID: begin
          keep = mt_on && event_value == -32'sd1;
          cmd.op = OP_TEND;
          cmd.kind = KIND_TOUCH;
          cmd.rel_x = -32'sd1;
          cmd.rel_y = -32'sd1;
        end
        default: keep = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_slot <= '0;
    end else if (accept && slot_hit) begin
      cur_slot <= event_value[SLOT_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== src/iet_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
// Depends on iet_pkg.
`default_nettype none

module iet_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire iet_pkg::cmd_t wdata,
  output logic               full,
  input  wire logic          rd_en,
  output iet_pkg::cmd_t      rdata,
  output logic               empty
);

  import iet_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);

  cmd_t          mem [CMD_DEPTH];
  logic [PW-1:0] rptr;
  logic [PW-1:0] wptr;
  logic [PW:0]   count;

  assign full = (count == (PW + 1)'(CMD_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rptr <= '0;
      wptr <= '0;
      count <= '0;
    end else begin
      if (wr_en && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en && !empty) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (PW + 1)'(wr_en && !full) - (PW + 1)'(rd_en && !empty);
    end
  end

endmodule

`default_nettype wire

// ===== src/iet_div.sv =====
// Restoring divider for coordinate scaling, one quotient bit per cycle.
// The quotient is known to fit in QUOT_W bits. Depends on iet_pkg.
`default_nettype none

module iet_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [47:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [15:0]      quot
);

  import iet_pkg::*;

  localparam int CW = $clog2(QUOT_W + 1);

  logic [31:0]       rem;
  logic [15:0]       low;
  logic [31:0]       dvs;
  logic [CW-1:0]     cnt;
  logic [32:0]       trial;
  logic              fits;

  assign trial = {rem, low[15]};
  assign fits = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(QUOT_W);
        rem <= dividend[47:16];
        low <= dividend[15:0];
        dvs <= divisor;
        quot <= '0;
      end else if (busy) begin
        rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
        quot <= {quot[14:0], fits};
        low <= {low[14:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/iet_back.sv =====
// Back end: carries out commands, keeps the per-slot coordinates and scales them.
// Depends on iet_pkg, iet_ram and iet_div; holds the result register.
`default_nettype none

module iet_back #(
  parameter int TOUCH_SLOTS = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire iet_pkg::cfg_t cfg,
  input  wire logic          fifo_empty,
  input  wire iet_pkg::cmd_t fifo_data,
  output logic               fifo_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic [2:0]         kind,
  output logic [9:0]         code_or_slot,
  output logic signed [31:0] abs_x,
  output logic signed [31:0] abs_y,
  output logic signed [31:0] rel_x,
  output logic signed [31:0] rel_y
);

  import iet_pkg::*;

  localparam int SLOT_W = (TOUCH_SLOTS > 1) ? $clog2(TOUCH_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_MUL,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  state_t             state;
  cmd_t               c;
  logic               rvalid;
  logic               vld_x [TOUCH_SLOTS];
  logic               vld_y [TOUCH_SLOTS];
  logic [31:0]        rdx;
  logic [31:0]        rdy;
  logic               we_x;
  logic               we_y;
  logic [SLOT_W-1:0]  cslot;
  logic signed [31:0] cur_x;
  logic signed [31:0] cur_y;
  logic signed [31:0] nx;
  logic signed [31:0] ny;
  logic signed [31:0] px;
  logic signed [31:0] py;
  logic signed [32:0] spx;
  logic signed [32:0] spy;
  logic signed [32:0] dxs;
  logic signed [32:0] dys;
  logic               inb;
  logic               scale_off;
  logic [31:0]        dx;
  logic [31:0]        dy;
  logic [31:0]        span_x;
  logic [31:0]        span_y;
  logic [47:0]        prod_x;
  logic [47:0]        prod_y;
  logic               div_start;
  logic               x_busy;
  logic               y_busy;
  logic               x_done;
  logic               y_done;
  logic [15:0]        qx;
  logic [15:0]        qy;
  logic signed [31:0] ox;
  logic signed [31:0] oy;

  assign cslot = c.slot[SLOT_W-1:0];
  assign fifo_pop = (state == S_IDLE) && !fifo_empty;
  assign empty = !rvalid;
  assign we_x = (state == S_READ) && c.op == OP_AXIS && !c.is_y;
  assign we_y = (state == S_READ) && c.op == OP_AXIS && c.is_y;
  assign div_start = (state == S_START);

  iet_ram #(.WIDTH(32), .DEPTH(TOUCH_SLOTS)) u_ram_x (
    .clk   (clk),
    .we    (we_x),
    .waddr (cslot),
    .wdata (c.value),
    .raddr (fifo_data.slot[SLOT_W-1:0]),
    .rdata (rdx)
  );

  iet_ram #(.WIDTH(32), .DEPTH(TOUCH_SLOTS)) u_ram_y (
    .clk   (clk),
    .we    (we_y),
    .waddr (cslot),
    .wdata (c.value),
    .raddr (fifo_data.slot[SLOT_W-1:0]),
    .rdata (rdy)
  );

  iet_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_x),
    .divisor  (span_x),
    .busy     (x_busy),
    .done     (x_done),
    .quot     (qx)
  );

  iet_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_y),
    .divisor  (span_y),
    .busy     (y_busy),
    .done     (y_done),
    .quot     (qy)
  );

  always_comb begin
    cur_x = vld_x[cslot] ? $signed(rdx) : -32'sd1;
    cur_y = vld_y[cslot] ? $signed(rdy) : -32'sd1;
    if (c.op == OP_AXIS) begin
      nx = c.is_y ? cur_x : c.value;
      ny = c.is_y ? c.value : cur_y;
    end else begin
      nx = cur_x[31] ? 32'sd0 : cur_x;
      ny = cur_y[31] ? 32'sd0 : cur_y;
    end
    spx = {cfg.x_max[31], cfg.x_max} - {cfg.x_min[31], cfg.x_min};
    spy = {cfg.y_max[31], cfg.y_max} - {cfg.y_min[31], cfg.y_min};
    dxs = {px[31], px} - {cfg.x_min[31], cfg.x_min};
    dys = {py[31], py} - {cfg.y_min[31], cfg.y_min};
    inb = px >= cfg.x_min && px <= cfg.x_max && py >= cfg.y_min && py <= cfg.y_max;
    scale_off = cfg.screen_w == 16'd0 || cfg.screen_h == 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rvalid <= 1'b0;
      for (int i = 0; i < TOUCH_SLOTS; i++) begin
        vld_x[i] <= 1'b0;
        vld_y[i] <= 1'b0;
      end
    end else begin
      if (pop && rvalid) begin
        rvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!fifo_empty) begin
            c <= fifo_data;
            ox <= '0;
            oy <= '0;
            state <= (fifo_data.op == OP_EMIT) ? S_OUT : S_READ;
          end
        end
        S_READ: begin
          if (we_x) begin
            vld_x[cslot] <= 1'b1;
          end
          if (we_y) begin
            vld_y[cslot] <= 1'b1;
          end
          px <= nx;
          py <= ny;
          if (c.op == OP_AXIS && (nx == -32'sd1 || ny == -32'sd1)) begin
            state <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          dx <= dxs[31:0];
          dy <= dys[31:0];
          span_x <= spx[31:0];
          span_y <= spy[31:0];
          if (scale_off || (spx != '0 && spy != '0 && inb)) begin
            if (c.op == OP_TEND) begin
              vld_x[cslot] <= 1'b0;
              vld_y[cslot] <= 1'b0;
            end
            ox <= px;
            oy <= py;
            state <= scale_off ? S_OUT : S_MUL;
          end else begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          prod_x <= cfg.screen_w * dx;
          prod_y <= cfg.screen_h * dy;
          state <= S_START;
        end
        S_START: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (x_done) begin
            ox <= $signed({16'd0, qx});
            oy <= $signed({16'd0, qy});
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rvalid) begin
            rvalid <= 1'b1;
            kind <= c.kind;
            code_or_slot <= (c.op == OP_EMIT) ? c.code : 10'(c.slot);
            abs_x <= ox;
            abs_y <= oy;
            rel_x <= c.rel_x;
            rel_y <= c.rel_y;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    x_done == y_done && x_busy == y_busy)
    else $error("coordinate dividers out of step");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    rvalid && !pop |=> rvalid && $stable(abs_x) && $stable(kind))
    else $error("pending result changed before its transaction");

  a_div_only_when_waiting: assert property (@(posedge clk) disable iff (rst)
    x_busy |-> state == S_DIV)
    else $error("divider running outside the divide state");

endmodule

`default_nettype wire

// ===== src/input_event_translator_core.sv =====
// Input event translator: a key, relative or wheel event goes from the queue straight to
// the output state; an absolute event passes the read and check states, which may drop it,
// then, when scaled, the multiply, start and divide states of the 16-step divider.
// The back end works on one command at a time; the front end keeps accepting into a
// four-entry queue meanwhile, until it is full.
// Synchronous reset clears the configuration, the current slot and all slot valid flags.
// Depends on iet_pkg, iet_front, iet_cmd_fifo and iet_back.
`default_nettype none

module input_event_translator_core #(
  parameter int TOUCH_SLOTS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [4:0]         event_type,
  input  wire logic [9:0]         event_code,
  input  wire logic signed [31:0] event_value,
  output logic                    empty,
  input  wire logic               pop,
  output logic [2:0]              kind,
  output logic [9:0]              code_or_slot,
  output logic signed [31:0]      abs_x,
  output logic signed [31:0]      abs_y,
  output logic signed [31:0]      rel_x,
  output logic signed [31:0]      rel_y
);

  import iet_pkg::*;

  cfg_t cfg;
  cmd_t f_cmd;
  cmd_t q_cmd;
  logic f_push;
  logic q_empty;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MODE:     cfg.mode <= cfg_data[2:0];
        CFG_SCREEN_W: cfg.screen_w <= cfg_data[15:0];
        CFG_SCREEN_H: cfg.screen_h <= cfg_data[15:0];
        CFG_X_MIN:    cfg.x_min <= cfg_data;
        CFG_X_MAX:    cfg.x_max <= cfg_data;
        CFG_Y_MIN:    cfg.y_min <= cfg_data;
        CFG_Y_MAX:    cfg.y_max <= cfg_data;
        default:      cfg <= cfg;
      endcase
    end
  end

  iet_front #(.TOUCH_SLOTS(TOUCH_SLOTS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .push        (push),
    .event_type  (event_type),
    .event_code  (event_code),
    .event_value (event_value),
    .full        (full),
    .cmd_push    (f_push),
    .cmd         (f_cmd)
  );

  iet_cmd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (f_push),
    .wdata (f_cmd),
    .full  (full),
    .rd_en (q_pop),
    .rdata (q_cmd),
    .empty (q_empty)
  );

  iet_back #(.TOUCH_SLOTS(TOUCH_SLOTS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fifo_empty   (q_empty),
    .fifo_data    (q_cmd),
    .fifo_pop     (q_pop),
    .pop          (pop),
    .empty        (empty),
    .kind         (kind),
    .code_or_slot (code_or_slot),
    .abs_x        (abs_x),
    .abs_y        (abs_y),
    .rel_x        (rel_x),
    .rel_y        (rel_y)
  );

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for input_event_translator_core: directed and random input events under several
// register settings, with results checked against a built-in scoreboard and predictor.
// Depends on iet_pkg and the input_event_translator_core RTL.
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import iet_pkg::*;

  localparam int LIMIT = 800000;
  localparam int SETTLE = 40;

  typedef struct {
    logic [2:0] kind;
    logic [9:0] code;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
  } pointer_evt_t;

  class pointer_scoreboard;
    pointer_evt_t pending_q[$];
    int errors = 0;
    logic [2:0] mode = '0;
    longint scr_w = 0, scr_h = 0, x_min = 0, x_max = 0, y_min = 0, y_max = 0;
    logic [3:0] cur_slot = '0;
    longint last_x[16];
    longint last_y[16];

    function new();
      foreach (last_x[i]) begin
        last_x[i] = -1;
        last_y[i] = -1;
      end
    endfunction

    function void report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        CFG_MODE: mode = d[2:0];
        CFG_SCREEN_W: scr_w = d[15:0];
        CFG_SCREEN_H: scr_h = d[15:0];
        CFG_X_MIN: x_min = longint'($signed(d));
        CFG_X_MAX: x_max = longint'($signed(d));
        CFG_Y_MIN: y_min = longint'($signed(d));
        CFG_Y_MAX: y_max = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function void add(logic [2:0] k, logic [9:0] c, longint ax, longint ay,
                      longint rx, longint ry);
      pointer_evt_t e;
      e.kind = k;
      e.code = c;
      e.ax = ax[31:0];
      e.ay = ay[31:0];
      e.rx = rx[31:0];
      e.ry = ry[31:0];
      pending_q.push_back(e);
    endfunction

    function bit fit_screen(inout longint x, inout longint y);
      longint sx, sy;
      sx = x_max - x_min;
      sy = y_max - y_min;
      if (scr_w == 0 || scr_h == 0) return 1;
      if (sx == 0 || sy == 0) return 0;
      if (x < x_min || y < y_min || x > x_max || y > y_max) return 0;
      x = (scr_w * (x - x_min)) / sx;
      y = (scr_h * (y - y_min)) / sy;
      return 1;
    endfunction

    function void axis_update(bit is_y, bit motion, longint v);
      longint x, y;
      if (is_y) last_y[cur_slot] = v;
      else last_x[cur_slot] = v;
      x = last_x[cur_slot];
      y = last_y[cur_slot];
      if (x == -1 || y == -1) return;
      if (!fit_screen(x, y)) return;
      add(motion ? KIND_MOTION : KIND_TOUCH, 10'(cur_slot), x, y, 0, 0);
    endfunction

    function void lift_touch();
      longint x, y;
      x = last_x[cur_slot] < 0 ? 0 : last_x[cur_slot];
      y = last_y[cur_slot] < 0 ? 0 : last_y[cur_slot];
      if (!fit_screen(x, y)) return;
      last_x[cur_slot] = -1;
      last_y[cur_slot] = -1;
      add(KIND_TOUCH, 10'(cur_slot), x, y, -1, -1);
    endfunction

    function void note_event(logic [4:0] t, logic [9:0] c, logic signed [31:0] value);
      longint v;
      bit mt_on, dev_mt;
      v = value;
      mt_on = mode[0];
      dev_mt = mode[1];
      if (mode[2]) return;
      if (t == EVT_KEY && v == 2) return;
      if (t == EVT_SYN || t == EVT_MSC) return;
      if (t == EVT_KEY) begin
        if (dev_mt && mt_on) return;
        if (c == KEY_TOUCH_BTN) c = KEY_LEFT_BTN;
        if (v == 0) add(KIND_RELEASE, c, 0, 0, 0, 0);
        else if (v == 1) add(KIND_PRESS, c, 0, 0, 0, 0);
      end else if (t == EVT_REL) begin
        case (c)
          RCODE_X: add(KIND_MOTION, 0, 0, 0, v, 0);
          RCODE_Y: add(KIND_MOTION, 0, 0, 0, 0, v);
          RCODE_HWHEEL: add(KIND_WHEEL, 0, 0, 0, v, 0);
          RCODE_WHEEL: add(KIND_WHEEL, 0, 0, 0, 0, v);
          default: ;
        endcase
      end else if (t == EVT_ABS) begin
        case (c)
          ACODE_WHEEL: add(KIND_WHEEL, 0, 0, 0, 0, v);
          ACODE_X: if (!(dev_mt && mt_on)) axis_update(0, 1, v);
          ACODE_Y: if (!(dev_mt && mt_on)) axis_update(1, 1, v);
          ACODE_MT_X: if (mt_on) axis_update(0, 0, v);
          ACODE_MT_Y: if (mt_on) axis_update(1, 0, v);
          ACODE_TRKID: if (mt_on && v == -1) lift_touch();
          ACODE_SLOT: if (mt_on && v >= 0 && v < 16) cur_slot = v[3:0];
          default: ;
        endcase
      end
    endfunction

    function void check_result(pointer_evt_t got);
      pointer_evt_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result kind %0d", got.kind));
        return;
      end
      e = pending_q.pop_front();
      if (got.kind !== e.kind) report($sformatf("kind %0d, want %0d", got.kind, e.kind));
      if (got.code !== e.code) report($sformatf("code_or_slot %h, want %h", got.code, e.code));
      if (got.ax !== e.ax) report($sformatf("abs_x %h, want %h", got.ax, e.ax));
      if (got.ay !== e.ay) report($sformatf("abs_y %h, want %h", got.ay, e.ay));
      if (got.rx !== e.rx) report($sformatf("rel_x %h, want %h", got.rx, e.rx));
      if (got.ry !== e.ry) report($sformatf("rel_y %h, want %h", got.ry, e.ry));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic push = 0;
  logic full;
  logic [4:0] event_type = '0;
  logic [9:0] event_code = '0;
  logic signed [31:0] event_value = '0;
  logic empty;
  logic pop = 0;
  logic [2:0] kind;
  logic [9:0] code_or_slot;
  logic signed [31:0] abs_x, abs_y, rel_x, rel_y;

  pointer_scoreboard sb = new();
  int send_pct = 0;
  int stall_pct = 0;
  int cycles = 0;

  input_event_translator_core uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .push(push), .full(full),
    .event_type(event_type), .event_code(event_code), .event_value(event_value),
    .empty(empty), .pop(pop),
    .kind(kind), .code_or_slot(code_or_slot),
    .abs_x(abs_x), .abs_y(abs_y), .rel_x(rel_x), .rel_y(rel_y)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    pointer_evt_t got;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("input_event_translator_core verification failed");
      $finish;
    end
    pop <= ($urandom_range(99) >= stall_pct);
    if (!rst) begin
      if (push && !full) sb.note_event(event_type, event_code, event_value);
      if (pop && !empty) begin
        got.kind = kind;
        got.code = code_or_slot;
        got.ax = abs_x;
        got.ay = abs_y;
        got.rx = rel_x;
        got.ry = rel_y;
        sb.check_result(got);
      end
    end
  end

  task automatic write_regs(logic [31:0] regs[7]);
    for (int i = 0; i < 7; i++) begin
      cfg_valid <= 1;
      cfg_index <= 3'(i);
      cfg_data <= regs[i];
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(3'(i), regs[i]);
    end
    cfg_valid <= 0;
  endtask

  task automatic send_event(logic [4:0] t, logic [9:0] c, logic signed [31:0] v);
    if (push && $urandom_range(99) < send_pct) begin
      push <= 0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1;
    event_type <= t;
    event_code <= c;
    event_value <= v;
    do @(posedge clk); while (full);
  endtask

  task automatic drain();
    push <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(longint lo, longint hi);
    longint r;
    int sel;
    sel = $urandom_range(99);
    r = longint'({$urandom, $urandom} >> 1);
    if (sel < 70 && hi >= lo) return 32'(lo + r % (hi - lo + 1));
    if (sel < 78) return 32'(lo);
    if (sel < 86) return 32'(hi);
    if (sel < 92) return '1;
    return $urandom;
  endfunction

  task automatic random_event();
    logic [9:0] c;
    logic [31:0] v;
    int sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      c = $urandom_range(3) == 0 ? KEY_TOUCH_BTN : 10'($urandom);
      case ($urandom_range(5))
        0, 1: v = 0;
        2, 3: v = 1;
        4: v = 2;
        default: v = $urandom;
      endcase
      send_event(EVT_KEY, c, v);
    end else if (sel < 35) begin
      case ($urandom_range(4))
        0: c = RCODE_X;
        1: c = RCODE_Y;
        2: c = RCODE_HWHEEL;
        3: c = RCODE_WHEEL;
        default: c = 10'($urandom);
      endcase
      send_event(EVT_REL, c, $urandom);
    end else if (sel < 90) begin
      case ($urandom_range(15))
        0, 1: send_event(EVT_ABS, ACODE_X, pick_coord(sb.x_min, sb.x_max));
        2, 3: send_event(EVT_ABS, ACODE_Y, pick_coord(sb.y_min, sb.y_max));
        4, 5, 6: send_event(EVT_ABS, ACODE_MT_X, pick_coord(sb.x_min, sb.x_max));
        7, 8, 9: send_event(EVT_ABS, ACODE_MT_Y, pick_coord(sb.y_min, sb.y_max));
        10, 11: send_event(EVT_ABS, ACODE_TRKID,
                           $urandom_range(3) == 0 ? 32'($urandom_range(9)) : '1);
        12, 13: send_event(EVT_ABS, ACODE_SLOT,
                           $urandom_range(5) == 0 ? $urandom : 32'($urandom_range(15)));
        14: send_event(EVT_ABS, ACODE_WHEEL, $urandom);
        default: send_event(EVT_ABS, 10'($urandom), $urandom);
      endcase
    end else if (sel < 95) begin
      send_event($urandom_range(1) ? EVT_SYN : EVT_MSC, 10'($urandom), $urandom);
    end else begin
      send_event(5'($urandom), 10'($urandom), $urandom);
    end
  endtask

  function automatic logic [31:0] pick_screen();
    case ($urandom_range(5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(4096, 1);
    endcase
  endfunction

  initial begin
    logic [31:0] regs[7];
    longint lo, hi;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    regs = '{32'd1, 32'd640, 32'd480, 32'd0, 32'd1000, 32'd0, 32'd1000};
    write_regs(regs);
    send_event(EVT_SYN, 10'd0, 32'd0);
    send_event(EVT_MSC, 10'h3FF, 32'hFFFF_FFFF);
    send_event(5'h1F, 10'd0, 32'd1);
    send_event(EVT_KEY, 10'h3FF, 32'd1);
    send_event(EVT_KEY, 10'h3FF, 32'd0);
    send_event(EVT_KEY, 10'd30, 32'd2);
    send_event(EVT_KEY, 10'd30, 32'd7);
    send_event(EVT_KEY, KEY_TOUCH_BTN, 32'd1);
    send_event(EVT_REL, RCODE_X, 32'h8000_0000);
    send_event(EVT_REL, RCODE_Y, 32'h7FFF_FFFF);
    send_event(EVT_REL, RCODE_HWHEEL, -32'sd1);
    send_event(EVT_REL, RCODE_WHEEL, 32'd1);
    send_event(EVT_REL, 10'd9, 32'd5);
    send_event(EVT_ABS, ACODE_WHEEL, -32'sd3);
    send_event(EVT_ABS, ACODE_X, 32'd500);
    send_event(EVT_ABS, ACODE_Y, 32'd1000);
    send_event(EVT_ABS, ACODE_X, 32'd2000);
    send_event(EVT_ABS, ACODE_SLOT, 32'd3);
    send_event(EVT_ABS, ACODE_MT_X, 32'd0);
    send_event(EVT_ABS, ACODE_MT_Y, 32'd0);
    send_event(EVT_ABS, ACODE_SLOT, 32'd16);
    send_event(EVT_ABS, ACODE_SLOT, -32'sd1);
    send_event(EVT_ABS, ACODE_TRKID, 32'd5);
    send_event(EVT_ABS, ACODE_TRKID, -32'sd1);
    send_event(EVT_ABS, ACODE_TRKID, -32'sd1);
    drain();

    for (int p = 0; p < 9; p++) begin
      regs[CFG_MODE] = p < 8 ? 32'(p) : 32'($urandom_range(3));
      regs[CFG_SCREEN_W] = pick_screen();
      regs[CFG_SCREEN_H] = pick_screen();
      case (p % 4)
        0: begin
          regs[CFG_X_MIN] = 32'h8000_0000;
          regs[CFG_X_MAX] = 32'h7FFF_FFFF;
          regs[CFG_Y_MIN] = 32'h8000_0000;
          regs[CFG_Y_MAX] = 32'h7FFF_FFFF;
        end
        1: begin
          regs[CFG_X_MIN] = 32'd100;
          regs[CFG_X_MAX] = 32'd100;
          regs[CFG_Y_MIN] = 32'd0;
          regs[CFG_Y_MAX] = 32'd50;
        end
        default: begin
          lo = $signed(32'($urandom_range(2000))) - 1000;
          hi = lo + $urandom_range(5000, 1);
          regs[CFG_X_MIN] = 32'(lo);
          regs[CFG_X_MAX] = 32'(hi);
          regs[CFG_Y_MIN] = 32'(lo + 7);
          regs[CFG_Y_MAX] = $urandom_range(4) == 0 ? 32'(lo) : 32'(hi + 300);
        end
      endcase
      write_regs(regs);
      for (int i = 0; i < 80; i++) begin
        case ((i / 20) % 4)
          0: begin send_pct = 0; stall_pct = 0; end
          1: begin send_pct = 55; stall_pct = 0; end
          2: begin send_pct = 0; stall_pct = 55; end
          default: begin send_pct = 10; stall_pct = 10; end
        endcase
        random_event();
      end
      stall_pct = 0;
      drain();
    end

    if (sb.errors == 0) begin
      $display("input_event_translator_core verification clean");
    end else begin
      $display("input_event_translator_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
